### hw/rtl/sfr_pkg.sv
// Shared types and constants for the sum-8 frame receiver.
// Used by sfr_parser, sfr_ack_tx and sum8_frame_receiver_with_ack.
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CFG_IDX_MAX_PAYLOAD = 1'b0;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd49;

  localparam logic [BYTE_W-1:0] HDR_A = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_B = 8'hAF;
  localparam logic [BYTE_W-1:0] FUNC_LIMIT = 8'hF1;
  localparam logic [BYTE_W-1:0] ACK_ID = 8'hEF;
  localparam logic [BYTE_W-1:0] ACK_LEN = 8'h02;
  localparam logic [BYTE_W-1:0] ACK_FUNC_LO = 8'h10;
  localparam logic [BYTE_W-1:0] ACK_FUNC_HI = 8'h15;
  localparam logic [BYTE_W-1:0] ACK_HDR_SUM = HDR_A + HDR_A + ACK_ID + ACK_LEN;

  localparam logic [2:0] ACK_BEAT_FUNC = 3'd4;
  localparam logic [2:0] ACK_BEAT_SUM = 3'd5;
  localparam logic [2:0] ACK_BEAT_LAST = 3'd6;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] func;
    logic [BYTE_W-1:0] sum;
  } ack_req_t;

endpackage

### hw/rtl/sfr_parser.sv
// Input register and frame parser state for the sum-8 frame receiver.
// Depends on sfr_pkg for constants and the acknowledge request struct.
module sfr_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [sfr_pkg::BYTE_W-1:0] s_tdata,
  input  logic [sfr_pkg::BYTE_W-1:0] max_payload,
  output sfr_pkg::ack_req_t         ack_req,
  input  logic                      ack_ready
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR_A = 3'd1;
  localparam logic [2:0] PH_HDR_B = 3'd2;
  localparam logic [2:0] PH_FUNC = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SUM = 3'd5;

  logic                       in_valid;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic [2:0]                 phase, phase_next;
  logic [sfr_pkg::BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [sfr_pkg::BYTE_W-1:0] func_code, func_code_next;
  logic [sfr_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic                       sum_ok;
  logic                       consume;

  always_comb begin
    sum_ok = (phase == PH_SUM) && (in_byte == running_sum) &&
             (func_code inside {[sfr_pkg::ACK_FUNC_LO:sfr_pkg::ACK_FUNC_HI]});
    ack_req.valid = in_valid && sum_ok;
    ack_req.func  = func_code;
    ack_req.sum   = running_sum;
    consume  = in_valid && (!sum_ok || ack_ready);
    s_tready = !in_valid || consume;
  end

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    func_code_next   = func_code;
    running_sum_next = running_sum;
    case (phase)
      PH_IDLE: begin
        if (in_byte == sfr_pkg::HDR_A) begin
          phase_next       = PH_HDR_A;
          running_sum_next = in_byte;
        end
      end
      PH_HDR_A: begin
        if (in_byte == sfr_pkg::HDR_B) begin
          phase_next       = PH_HDR_B;
          running_sum_next = running_sum + in_byte;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HDR_B: begin
        if (in_byte < sfr_pkg::FUNC_LIMIT) begin
          phase_next       = PH_FUNC;
          func_code_next   = in_byte;
          running_sum_next = running_sum + in_byte;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_FUNC: begin
        if (in_byte != '0 && in_byte <= max_payload) begin
          phase_next       = PH_PAYLOAD;
          bytes_left_next  = in_byte;
          running_sum_next = running_sum + in_byte;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left != '0) begin
          running_sum_next = running_sum + in_byte;
          bytes_left_next  = bytes_left - 1'b1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_SUM;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      phase       <= PH_IDLE;
      bytes_left  <= '0;
      func_code   <= '0;
      running_sum <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (consume) begin
        phase       <= phase_next;
        bytes_left  <= bytes_left_next;
        func_code   <= func_code_next;
        running_sum <= running_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

### hw/rtl/sfr_ack_tx.sv
// Acknowledge frame sender: holds function and sum, emits seven beats.
// Depends on sfr_pkg for constants and the acknowledge request struct.
module sfr_ack_tx (
  input  logic                       clk,
  input  logic                       rst,
  input  sfr_pkg::ack_req_t          ack_req,
  output logic                       ack_ready,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sfr_pkg::BYTE_W-1:0] m_tdata,
  output logic                       m_tlast
);

  logic                       active;
  logic [2:0]                 beat;
  logic [sfr_pkg::BYTE_W-1:0] func;
  logic [sfr_pkg::BYTE_W-1:0] sum;
  logic [sfr_pkg::BYTE_W-1:0] cs;
  logic                       load;
  logic                       take;

  always_comb begin
    m_tvalid  = active;
    m_tlast   = (beat == sfr_pkg::ACK_BEAT_LAST);
    take      = active && m_tready;
    ack_ready = !active || (take && m_tlast);
    load      = ack_req.valid && ack_ready;
    case (beat)
      3'd0, 3'd1:             m_tdata = sfr_pkg::HDR_A;
      3'd2:                   m_tdata = sfr_pkg::ACK_ID;
      3'd3:                   m_tdata = sfr_pkg::ACK_LEN;
      sfr_pkg::ACK_BEAT_FUNC: m_tdata = func;
      sfr_pkg::ACK_BEAT_SUM:  m_tdata = sum;
      default:                m_tdata = cs;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      beat   <= '0;
    end else if (load) begin
      active <= 1'b1;
      beat   <= '0;
    end else if (take) begin
      if (m_tlast) begin
        active <= 1'b0;
      end
      beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      func <= ack_req.func;
      sum  <= ack_req.sum;
      cs   <= sfr_pkg::ACK_HDR_SUM + ack_req.func + ack_req.sum;
    end
  end

endmodule

### hw/rtl/sum8_frame_receiver_with_ack.sv
// Sum-8 frame receiver with acknowledge: top level with register port.
// Depends on sfr_pkg, sfr_parser and sfr_ack_tx.
//
// Usage:
//   s_* carries received bytes, one per beat (tdata[7:0] = rx_byte).
//   The parser looks for AA AF, function, length (1..max_payload), payload
//   and a sum byte. A good frame with function 0x10..0x15 makes m_* send the
//   seven-beat acknowledge AA AA EF 02 function sum checksum; tlast marks
//   the seventh beat (tdata[7:0] = tx_byte, tlast = tx_last).
//   max_payload sits at APB address 0 (reset 49); write it only while idle.
// Timing:
//   One byte is taken per cycle through the input register while s_tready is
//   high. Once the sum byte sits in the input register, the acknowledge is
//   loaded into the sender, whose registered active flag drives the first
//   beat on m_*; the beats then go out one per cycle, paced by m_tready.
//   A new acknowledge waits only while the previous one is still being sent;
//   the parser then holds the sum byte and s_tready drops.
// Reset: synchronous, clears the parser to idle, drops any acknowledge in
//   flight and restores max_payload to 49.
module sum8_frame_receiver_with_ack (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sfr_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] tx_byte
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [sfr_pkg::BYTE_W-1:0] max_payload;
  sfr_pkg::ack_req_t          ack_req;
  logic                       ack_ready;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[sfr_pkg::CFG_ADDR_W-1] == sfr_pkg::CFG_IDX_MAX_PAYLOAD);

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(sfr_pkg::CFG_DATA_W-sfr_pkg::BYTE_W){1'b0}}, max_payload};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= sfr_pkg::MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_payload <= pwdata[sfr_pkg::BYTE_W-1:0];
    end
  end

  sfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .max_payload (max_payload),
    .ack_req     (ack_req),
    .ack_ready   (ack_ready)
  );

  sfr_ack_tx u_ack_tx (
    .clk       (clk),
    .rst       (rst),
    .ack_req   (ack_req),
    .ack_ready (ack_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  a_req_held: assert property (@(posedge clk) disable iff (rst)
    ack_req.valid && !ack_ready |=> ack_req.valid && $stable(ack_req.func) &&
    $stable(ack_req.sum))
    else $error("acknowledge request dropped while sender busy");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !ack_req.valid |=> !m_tvalid)
    else $error("sender still active after last beat");

  a_req_stalls_input: assert property (@(posedge clk) disable iff (rst)
    ack_req.valid && !ack_ready |-> !s_tready)
    else $error("input taken while acknowledge pending");

  a_cfg_reset: assert property (@(posedge clk)
    rst |=> max_payload == sfr_pkg::MAX_PAYLOAD_RESET)
    else $error("max_payload not restored by reset");
`endif

endmodule

### tb/tb_top.sv
// Self-checking bench for sum8_frame_receiver_with_ack: frames in on s_*, acks out on m_*.
// A small scoreboard class predicts the acknowledge beats; max_payload is set over APB.
// Depends on sfr_pkg and the RTL of the receiver.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [sfr_pkg::BYTE_W-1:0]     octet_t;
  typedef logic [sfr_pkg::CFG_ADDR_W-1:0] apb_addr_t;
  typedef logic [sfr_pkg::CFG_DATA_W-1:0] apb_word_t;

  localparam apb_addr_t MAX_PAYLOAD_ADDR =
    apb_addr_t'(4 * sfr_pkg::CFG_IDX_MAX_PAYLOAD);
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE = 8;
  localparam int HOLD_CYCLES = 400;

  class ack_scoreboard;
    typedef enum logic [2:0] {
      PH_IDLE, PH_GOT_A, PH_GOT_B, PH_GOT_FUNC, PH_PAYLOAD, PH_SUM
    } parse_phase_t;

    typedef struct packed {
      octet_t data;
      logic   last;
    } ack_beat_t;

    octet_t       max_len;
    parse_phase_t phase;
    octet_t       left;
    octet_t       func;
    octet_t       sum;
    ack_beat_t    beat_q[$];
    int           errors;

    function new();
      max_len = sfr_pkg::MAX_PAYLOAD_RESET;
      phase   = PH_IDLE;
      left    = '0;
      func    = '0;
      sum     = '0;
      errors  = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_rx(octet_t b);
      octet_t frame[7];
      octet_t cs;
      int     k;
      case (phase)
        PH_IDLE: begin
          if (b == sfr_pkg::HDR_A) begin
            phase = PH_GOT_A;
            sum   = b;
          end
        end
        PH_GOT_A: begin
          if (b == sfr_pkg::HDR_B) begin
            phase = PH_GOT_B;
            sum   = sum + b;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_GOT_B: begin
          if (b < sfr_pkg::FUNC_LIMIT) begin
            phase = PH_GOT_FUNC;
            func  = b;
            sum   = sum + b;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_GOT_FUNC: begin
          if (b != 0 && b <= max_len) begin
            phase = PH_PAYLOAD;
            left  = b;
            sum   = sum + b;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          if (left != 0) begin
            sum  = sum + b;
            left = left - 1'b1;
            if (left == 0) phase = PH_SUM;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_SUM: begin
          phase = PH_IDLE;
          if (b == sum && func >= sfr_pkg::ACK_FUNC_LO && func <= sfr_pkg::ACK_FUNC_HI) begin
            frame = '{sfr_pkg::HDR_A, sfr_pkg::HDR_A, sfr_pkg::ACK_ID, sfr_pkg::ACK_LEN,
                      func, sum, 8'h00};
            cs = '0;
            for (k = 0; k < 6; k++) cs = cs + frame[k];
            frame[6] = cs;
            for (k = 0; k < 7; k++) beat_q.push_back({frame[k], k == 6});
          end
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
    endfunction

    function void check_tx(octet_t d, logic l);
      ack_beat_t want;
      if (beat_q.size() == 0) begin
        report($sformatf("unexpected ack beat: got %h last %b", d, l));
        return;
      end
      want = beat_q.pop_front();
      if (want.data !== d || want.last !== l)
        report($sformatf("ack beat mismatch: expected %h last %b, got %h last %b",
                         want.data, want.last, d, l));
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [sfr_pkg::BYTE_W-1:0]     s_tdata;     // [7:0] rx_byte
  logic                           m_tvalid;
  logic                           m_tready;
  logic [sfr_pkg::BYTE_W-1:0]     m_tdata;     // [7:0] tx_byte
  logic                           m_tlast;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [sfr_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  ack_scoreboard sb;
  int            burst_left;
  int            gap_max;
  int            rx_count;
  int            cycle_count;
  int            hold_left;
  int            pat_age;
  logic          hold_req;
  logic [7:0]    stall_pat;

  sum8_frame_receiver_with_ack DUT (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_tx(m_tdata, m_tlast);
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age   = $urandom_range(80, 20);
        stall_pat = ($urandom_range(3, 0) == 0) ? 8'hFF : 8'($urandom);
        if (stall_pat == 0) stall_pat = 8'h01;
      end
      pat_age--;
      m_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  task automatic send_byte(input octet_t b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(16, 1);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_rx(b);
    rx_count++;
    burst_left--;
    @(negedge clk);
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_frame(input octet_t fn, input octet_t len, input int fill,
                            input bit sum_ok);
    octet_t acc;
    octet_t b;
    acc = sfr_pkg::HDR_A + sfr_pkg::HDR_B + fn + len;
    send_byte(sfr_pkg::HDR_A);
    send_byte(sfr_pkg::HDR_B);
    send_byte(fn);
    send_byte(len);
    repeat (len) begin
      b = (fill < 0) ? octet_t'($urandom) : octet_t'(fill);
      acc = acc + b;
      send_byte(b);
    end
    if (!sum_ok) acc = acc ^ octet_t'($urandom_range(255, 1));
    send_byte(acc);
  endtask

  task automatic random_sequence();
    octet_t lim;
    octet_t len;
    octet_t b;
    int     pick;
    lim  = sb.max_len;
    pick = $urandom_range(99, 0);
    len  = (lim > 8) ? octet_t'($urandom_range(8, 1)) : octet_t'($urandom_range(lim, 1));
    if (lim <= 64 && $urandom_range(7, 0) == 0) len = octet_t'($urandom_range(lim, 1));
    if (pick < 60) begin
      send_frame(octet_t'(sfr_pkg::ACK_FUNC_LO + $urandom_range(5, 0)), len, -1, 1'b1);
    end else if (pick < 70) begin
      send_frame(octet_t'($urandom_range(sfr_pkg::FUNC_LIMIT - 1, 0)), len, -1, 1'b1);
    end else if (pick < 78) begin
      send_frame(octet_t'(sfr_pkg::ACK_FUNC_LO + $urandom_range(5, 0)), len, -1, 1'b0);
    end else if (pick < 84) begin
      send_byte(sfr_pkg::HDR_A);
      send_byte(sfr_pkg::HDR_B);
      send_byte(octet_t'($urandom_range(sfr_pkg::FUNC_LIMIT - 1, 0)));
      if (lim == 8'hFF || $urandom_range(1, 0) == 0) send_byte(8'h00);
      else send_byte(octet_t'($urandom_range(255, int'(lim) + 1)));
    end else if (pick < 88) begin
      send_byte(sfr_pkg::HDR_A);
      send_byte(sfr_pkg::HDR_B);
      send_byte(octet_t'($urandom_range(255, sfr_pkg::FUNC_LIMIT)));
    end else if (pick < 92) begin
      b = octet_t'($urandom);
      if (b == sfr_pkg::HDR_B) b = sfr_pkg::HDR_A;
      send_byte(sfr_pkg::HDR_A);
      send_byte(b);
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(octet_t'($urandom));
    end
  endtask

  task automatic random_traffic(input int n);
    int start;
    start = rx_count;
    while (rx_count - start < n) random_sequence();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.beat_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_check(input octet_t v);
    apb_word_t got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_PAYLOAD_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== apb_word_t'(v))
      sb.report($sformatf("max_payload readback: expected %h, got %h", apb_word_t'(v), got));
    @(negedge clk);
  endtask

  task automatic cfg_write(input octet_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_PAYLOAD_ADDR;
    pwdata  <= apb_word_t'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.max_len = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    cfg_check(v);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 0;
    gap_max     = 3;
    rx_count    = 0;
    cycle_count = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    pat_age     = 0;
    stall_pat   = 8'hFF;
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    cfg_check(sfr_pkg::MAX_PAYLOAD_RESET);

    send_frame(sfr_pkg::ACK_FUNC_LO, 8'd1, 8'hFF, 1'b1);
    send_byte(sfr_pkg::HDR_A);
    send_byte(sfr_pkg::HDR_A);
    send_byte(sfr_pkg::HDR_A);
    send_byte(sfr_pkg::HDR_B);
    send_byte(sfr_pkg::FUNC_LIMIT);
    send_byte(sfr_pkg::HDR_A);
    send_byte(sfr_pkg::HDR_B);
    send_byte(sfr_pkg::ACK_FUNC_HI);
    send_byte(8'h00);

    // hold the ack side so the parser backs up and drops s_tready
    gap_max  = 0;
    hold_req = 1'b1;
    repeat (8)
      send_frame(octet_t'(sfr_pkg::ACK_FUNC_LO + $urandom_range(5, 0)), 8'd1, -1, 1'b1);
    gap_max = 4;
    random_traffic(30);
    drain();

    cfg_write(8'd1);
    send_byte(sfr_pkg::HDR_A);
    send_byte(sfr_pkg::HDR_B);
    send_byte(sfr_pkg::ACK_FUNC_HI);
    send_byte(8'd2);
    send_frame(sfr_pkg::ACK_FUNC_HI, 8'd1, 8'h00, 1'b1);
    gap_max = 0;
    random_traffic(30);
    drain();

    cfg_write(8'd255);
    gap_max = 2;
    send_frame(octet_t'(sfr_pkg::ACK_FUNC_LO + $urandom_range(5, 0)), 8'd255, -1, 1'b1);
    random_traffic(30);
    drain();

    cfg_write(octet_t'($urandom_range(254, 2)));
    gap_max = 6;
    random_traffic(30);
    drain();

    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_parser.sv
hw/rtl/sfr_ack_tx.sv
hw/rtl/sum8_frame_receiver_with_ack.sv
tb/tb_top.sv
